[hw/rtl/h264_rtp_fua_packetizer_assert.svh]
// assertion macros used by the checker file h264fua_checker.sv
`ifndef H264_RTP_FUA_PACKETIZER_ASSERT_SVH
`define H264_RTP_FUA_PACKETIZER_ASSERT_SVH

// same-cycle implication
`define FUA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FUA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/h264fua_pkg.sv]
`timescale 1ns / 1ps
package h264fua_pkg;

    localparam int MAX_NAL_BYTES = 65536;
    localparam int PACKET_LIMIT  = 1400;
    localparam int RTP_HDR_BYTES = 12;
    localparam int FU_HDR_BYTES  = 2;
    localparam int FRAG_BYTES    = PACKET_LIMIT - RTP_HDR_BYTES - FU_HDR_BYTES;
    localparam int MAX_FRAGS     = 48;
    localparam int FRAG_CAP      = 1 + MAX_FRAGS * FRAG_BYTES;
    localparam int SIZE_CAP      = (MAX_NAL_BYTES < FRAG_CAP) ? MAX_NAL_BYTES : FRAG_CAP;

    localparam int SIZE_W = 17;
    localparam int LEN_W  = 11;
    localparam int STEP_W = 17;
    localparam int ALU_W  = 32;

    localparam logic [4:0] FU_A_TYPE = 5'd28;

    localparam logic [2:0] ADDR_ENABLE = 3'd0;
    localparam logic [2:0] ADDR_STEP   = 3'd4;
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(3000);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REM,
        ST_FRAG,
        ST_SEND,
        ST_ADV,
        ST_TIME
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t            op;
        logic [ALU_W-1:0]   a;
        logic [ALU_W-1:0]   b;
    } alu_req_t;

endpackage

[hw/rtl/h264fua_if.sv]
`timescale 1ns / 1ps
interface h264fua_nal_if;
    import h264fua_pkg::*;

    logic              valid;
    logic              ready;
    logic [7:0]        nal_header;
    logic [SIZE_W-1:0] nal_size;

    modport source (output valid, nal_header, nal_size, input ready);
    modport sink (input valid, nal_header, nal_size, output ready);
endinterface

interface h264fua_pkt_if;
    import h264fua_pkg::*;

    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] packet_length;
    logic [15:0]      sequence_number;
    logic [31:0]      timestamp;
    logic             marker;
    logic             fragmented;
    logic [7:0]       fu_indicator;
    logic [7:0]       fu_header;
    logic [15:0]      payload_offset;
    logic [LEN_W-1:0] payload_length;
    logic [31:0]      octet_total;
    logic             last;

    modport source (
        output valid, packet_length, sequence_number, timestamp, marker, fragmented,
               fu_indicator, fu_header, payload_offset, payload_length, octet_total, last,
        input  ready
    );
    modport sink (
        input  valid, packet_length, sequence_number, timestamp, marker, fragmented,
               fu_indicator, fu_header, payload_offset, payload_length, octet_total, last,
        output ready
    );
endinterface

[hw/rtl/h264_rtp_fua_packetizer.sv]
`timescale 1ns / 1ps
// h264 rtp fu-a packetizer, descriptor level
// nal channel: one word per nal unit (header byte, size with start code removed)
// pkt channel: one word per rtp packet (lengths, seq, timestamp, fu-a bytes,
//   payload offset and running octet total)
// apb port: sending_enabled at 0x0, timestamp_step at 0x4; write only while idle
// a unit under 1400 bytes gives one packet, a larger one up to 48 fu-a fragments
// sequencing: after the nal word is taken the remainder state and the size and octet
//   add state run before the first packet is valid; each further packet passes the
//   remainder, size and octet add, send and offset advance states, all through one shared
//   32-bit adder; a marker unit adds a timestamp advance state after its last packet
// nal ready is high only while idle; with sending disabled a word is taken and
//   dropped, and the sequencer stays idle
// a stalled receiver holds the packet word in place and the sequencer waits
// reset clears the counters to zero, disables sending and sets the step to 3000
module h264_rtp_fua_packetizer (
    input  logic        clk,
    input  logic        rst_n,
    h264fua_nal_if.sink   nal,
    h264fua_pkt_if.source pkt,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import h264fua_pkg::*;

    state_t state_reg, state_next;

    logic              enabled_reg;
    logic [STEP_W-1:0] step_reg;
    logic [15:0]       seq_reg, seq_next;
    logic [31:0]       time_reg, time_next;
    logic [31:0]       octet_reg, octet_next;

    logic [7:0]        hdr_reg, hdr_next;
    logic [SIZE_W-1:0] total_reg, total_next;
    logic [SIZE_W-1:0] offset_reg, offset_next;
    logic [SIZE_W-1:0] rem_reg, rem_next;
    logic              frag_reg, frag_next;
    logic              first_reg, first_next;

    logic [LEN_W-1:0]  plen_reg, plen_next;
    logic [LEN_W-1:0]  flen_reg, flen_next;
    logic [7:0]        fh_reg, fh_next;
    logic              last_reg, last_next;

    alu_req_t          alu_req;
    logic [ALU_W-1:0]  alu_y;

    logic              nal_take;
    logic              pkt_take;
    logic              marker_unit;
    logic              fits;
    logic [LEN_W-1:0]  fsz;
    logic              flast;
    logic [SIZE_W-1:0] sat_size;
    logic              cfg_wr;

    h264fua_alu u_alu (
        .req (alu_req),
        .y   (alu_y)
    );

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        if (paddr[2] == ADDR_STEP[2])
        begin
            prdata = {{(32-STEP_W){1'b0}}, step_reg};
        end
        else
        begin
            prdata = {31'b0, enabled_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            step_reg    <= STEP_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == ADDR_STEP[2])
            begin
                step_reg <= pwdata[STEP_W-1:0];
            end
            else
            begin
                enabled_reg <= pwdata[0];
            end
        end
    end

    assign nal_take    = nal.valid && nal.ready;
    assign pkt_take    = pkt.valid && pkt.ready;
    assign marker_unit = (hdr_reg[4:0] < 5'd6);
    assign sat_size    = (nal.nal_size > SIZE_W'(SIZE_CAP)) ? SIZE_W'(SIZE_CAP) : nal.nal_size;

    assign fits  = (rem_reg <= SIZE_W'(FRAG_BYTES));
    assign flast = !frag_reg || fits;
    assign fsz   = flast ? rem_reg[LEN_W-1:0] : LEN_W'(FRAG_BYTES);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (nal_take && enabled_reg)
                begin
                    state_next = ST_REM;
                end
            end
            ST_REM:  state_next = ST_FRAG;
            ST_FRAG: state_next = ST_SEND;
            ST_SEND:
            begin
                if (pkt_take)
                begin
                    if (!last_reg)
                    begin
                        state_next = ST_ADV;
                    end
                    else if (marker_unit)
                    begin
                        state_next = ST_TIME;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ADV:  state_next = ST_REM;
            ST_TIME: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and shared adder operands
    always_comb
    begin
        nal.ready   = 1'b0;
        pkt.valid   = 1'b0;
        alu_req.op  = ALU_ADD;
        alu_req.a   = '0;
        alu_req.b   = '0;
        case (state_reg)
            ST_IDLE: nal.ready = 1'b1;
            ST_REM:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = {{(ALU_W-SIZE_W){1'b0}}, total_reg};
                alu_req.b  = {{(ALU_W-SIZE_W){1'b0}}, offset_reg};
            end
            ST_FRAG:
            begin
                alu_req.a = octet_reg;
                alu_req.b = {{(ALU_W-LEN_W){1'b0}}, fsz}
                          + (frag_reg ? ALU_W'(FU_HDR_BYTES) : '0);
            end
            ST_SEND: pkt.valid = 1'b1;
            ST_ADV:
            begin
                alu_req.a = {{(ALU_W-SIZE_W){1'b0}}, offset_reg};
                alu_req.b = {{(ALU_W-LEN_W){1'b0}}, flen_reg};
            end
            ST_TIME:
            begin
                alu_req.a = time_reg;
                alu_req.b = {{(ALU_W-STEP_W){1'b0}}, step_reg};
            end
            default: ;
        endcase
    end

    // datapath registers
    always_comb
    begin
        hdr_next    = hdr_reg;
        total_next  = total_reg;
        offset_next = offset_reg;
        rem_next    = rem_reg;
        frag_next   = frag_reg;
        first_next  = first_reg;
        seq_next    = seq_reg;
        time_next   = time_reg;
        octet_next  = octet_reg;
        plen_next   = plen_reg;
        flen_next   = flen_reg;
        fh_next     = fh_reg;
        last_next   = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (nal_take)
                begin
                    hdr_next    = nal.nal_header;
                    total_next  = sat_size;
                    frag_next   = (sat_size >= SIZE_W'(PACKET_LIMIT));
                    offset_next = (sat_size >= SIZE_W'(PACKET_LIMIT)) ? SIZE_W'(1) : '0;
                    first_next  = 1'b1;
                end
            end
            ST_REM: rem_next = alu_y[SIZE_W-1:0];
            ST_FRAG:
            begin
                octet_next = alu_y;
                flen_next  = fsz;
                last_next  = flast;
                plen_next  = fsz + (frag_reg ? LEN_W'(RTP_HDR_BYTES + FU_HDR_BYTES)
                                             : LEN_W'(RTP_HDR_BYTES));
                fh_next    = frag_reg ? {first_reg, flast, 1'b0, hdr_reg[4:0]} : 8'h00;
            end
            ST_SEND:
            begin
                if (pkt_take)
                begin
                    seq_next   = seq_reg + 16'd1;
                    first_next = 1'b0;
                end
            end
            ST_ADV:  offset_next = alu_y[SIZE_W-1:0];
            ST_TIME: time_next = alu_y;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seq_reg   <= '0;
            time_reg  <= '0;
            octet_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            seq_reg   <= seq_next;
            time_reg  <= time_next;
            octet_reg <= octet_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg    <= hdr_next;
        total_reg  <= total_next;
        offset_reg <= offset_next;
        rem_reg    <= rem_next;
        frag_reg   <= frag_next;
        first_reg  <= first_next;
        plen_reg   <= plen_next;
        flen_reg   <= flen_next;
        fh_reg     <= fh_next;
        last_reg   <= last_next;
    end

    assign pkt.packet_length   = plen_reg;
    assign pkt.sequence_number = seq_reg;
    assign pkt.timestamp       = time_reg;
    assign pkt.marker          = last_reg && marker_unit;
    assign pkt.fragmented      = frag_reg;
    assign pkt.fu_indicator    = frag_reg ? {1'b0, hdr_reg[6:5], FU_A_TYPE} : 8'h00;
    assign pkt.fu_header       = fh_reg;
    assign pkt.payload_offset  = offset_reg[15:0];
    assign pkt.payload_length  = flen_reg;
    assign pkt.octet_total     = octet_reg;
    assign pkt.last            = last_reg;
endmodule

[hw/rtl/h264fua_alu.sv]
`timescale 1ns / 1ps
module h264fua_alu (
    input  h264fua_pkg::alu_req_t                req,
    output logic [h264fua_pkg::ALU_W-1:0]        y
);
    import h264fua_pkg::*;

    always_comb
    begin
        case (req.op)
            ALU_ADD: y = req.a + req.b;
            ALU_SUB: y = req.a - req.b;
            default: y = req.a;
        endcase
    end
endmodule

[hw/rtl/h264fua_checker.sv]
`timescale 1ns / 1ps
`include "h264_rtp_fua_packetizer_assert.svh"
module h264fua_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_last,
    input logic [15:0] out_seq,
    input logic [15:0] out_offset
);
    `FUA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_seq) && $stable(out_offset), "packet word changed while stalled")
    `FUA_ASSERT_NOW(a_busy_excl, clk, rst_n, out_valid, !in_ready,
        "nal word accepted while a packet is pending")
    `FUA_ASSERT_NEXT(a_gap_after_take, clk, rst_n, out_valid && out_ready, !out_valid,
        "packet word presented right after a handshake")
    `FUA_ASSERT_NEXT(a_frag_busy, clk, rst_n, out_valid && out_ready && !out_last,
        !in_ready && !(in_valid && in_ready), "unit released before its last fragment")
endmodule

bind h264_rtp_fua_packetizer h264fua_checker u_h264fua_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (nal.valid),
    .in_ready   (nal.ready),
    .out_valid  (pkt.valid),
    .out_ready  (pkt.ready),
    .out_last   (pkt.last),
    .out_seq    (pkt.sequence_number),
    .out_offset (pkt.payload_offset)
);

[tb/h264fua_stream_checker.sv]
`timescale 1ns / 1ps
module h264fua_stream_checker (
    input  logic        clk,
    input  logic        rst_n,
    h264fua_nal_if      nal,
    h264fua_pkt_if      pkt,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          packets_outstanding,
    output int          packet_count,
    output int          fragment_count,
    output int          dropped_units
);
    import h264fua_pkg::*;

    localparam int unsigned PKT_LIMIT     = 1400;
    localparam int unsigned RTP_HDR_LEN   = 12;
    localparam int unsigned FU_BYTES      = 2;
    localparam int unsigned FRAG_PAYLOAD  = PKT_LIMIT - RTP_HDR_LEN - FU_BYTES;
    localparam int unsigned MAX_FRAGMENTS = 48;
    localparam int unsigned NAL_LIMIT     = 65536;
    localparam int unsigned FRAG_LIMIT    = 1 + MAX_FRAGMENTS * FRAG_PAYLOAD;
    localparam int unsigned SIZE_LIMIT    = (NAL_LIMIT < FRAG_LIMIT) ? NAL_LIMIT : FRAG_LIMIT;
    localparam logic [4:0]  MARKER_TYPES  = 5'd6;
    localparam logic [7:0]  FU_START      = 8'h80;
    localparam logic [7:0]  FU_END        = 8'h40;
    localparam logic [16:0] STEP_AT_RESET = 17'd3000;

    typedef struct packed {
        logic [10:0] pkt_len;
        logic [15:0] seq;
        logic [31:0] ts;
        logic        mark;
        logic        frag;
        logic [7:0]  fu_ind;
        logic [7:0]  fu_hdr;
        logic [15:0] offset;
        logic [10:0] pay_len;
        logic [31:0] octets;
        logic        last_pkt;
    } rtp_pkt_t;

    rtp_pkt_t    packets_due[$];
    logic        send_on;
    logic [16:0] ts_step;
    logic [15:0] seq_num;
    logic [31:0] rtp_ts;
    logic [31:0] octet_count;

    function automatic void record_packet(input logic [10:0] len, input logic mark,
                                          input logic frag, input logic [7:0] ind,
                                          input logic [7:0] fh, input logic [15:0] offs,
                                          input logic [10:0] plen, input logic fin);
        packets_due.push_back('{len, seq_num, rtp_ts, mark, frag, ind, fh, offs, plen,
                                octet_count, fin});
        seq_num = seq_num + 16'd1;
    endfunction

    function automatic void packetize_unit(input logic [7:0] hdr, input logic [16:0] size_in);
        int unsigned total;
        int unsigned offs;
        int unsigned chunk;
        int unsigned nfrag;
        logic        marker_unit;
        logic        fin;
        logic [7:0]  indicator;
        logic [7:0]  fu_hdr;
        if (!send_on)
        begin
            dropped_units++;
            return;
        end
        total = 32'(size_in);
        if (total > SIZE_LIMIT)
            total = SIZE_LIMIT;
        marker_unit = (hdr[4:0] < MARKER_TYPES);
        if (total < PKT_LIMIT)
        begin
            octet_count = octet_count + total;
            record_packet(11'(total + RTP_HDR_LEN), marker_unit, 1'b0, 8'h00, 8'h00, 16'h0000,
                          11'(total), 1'b1);
        end
        else
        begin
            indicator = {1'b0, hdr[6:5], FU_A_TYPE};
            offs = 1;
            nfrag = 0;
            while (offs < total && nfrag < MAX_FRAGMENTS)
            begin
                chunk = total - offs;
                if (chunk > FRAG_PAYLOAD)
                    chunk = FRAG_PAYLOAD;
                fin = (offs + chunk >= total);
                fu_hdr = {3'b000, hdr[4:0]};
                if (nfrag == 0)
                    fu_hdr = fu_hdr | FU_START;
                if (fin)
                    fu_hdr = fu_hdr | FU_END;
                octet_count = octet_count + chunk + FU_BYTES;
                record_packet(11'(chunk + RTP_HDR_LEN + FU_BYTES), fin & marker_unit, 1'b1,
                              indicator, fu_hdr, 16'(offs), 11'(chunk), fin);
                fragment_count++;
                offs += chunk;
                nfrag++;
            end
        end
        if (marker_unit)
            rtp_ts = rtp_ts + ts_step;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void compare_packet();
        rtp_pkt_t want;
        packet_count++;
        if (packets_due.size() == 0)
        begin
            $display("%0t unexpected packet word: expected none, actual seq %0h len %0h",
                     $time, pkt.sequence_number, pkt.packet_length);
            fail_count++;
            return;
        end
        want = packets_due.pop_front();
        check_field("packet_length", 32'(want.pkt_len), 32'(pkt.packet_length));
        check_field("sequence_number", 32'(want.seq), 32'(pkt.sequence_number));
        check_field("timestamp", want.ts, pkt.timestamp);
        check_field("marker", 32'(want.mark), 32'(pkt.marker));
        check_field("fragmented", 32'(want.frag), 32'(pkt.fragmented));
        check_field("fu_indicator", 32'(want.fu_ind), 32'(pkt.fu_indicator));
        check_field("fu_header", 32'(want.fu_hdr), 32'(pkt.fu_header));
        check_field("payload_offset", 32'(want.offset), 32'(pkt.payload_offset));
        check_field("payload_length", 32'(want.pay_len), 32'(pkt.payload_length));
        check_field("octet_total", want.octets, pkt.octet_total);
        check_field("last", 32'(want.last_pkt), 32'(pkt.last));
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            packets_due.delete();
            send_on = 1'b0;
            ts_step = STEP_AT_RESET;
            seq_num = '0;
            rtp_ts = '0;
            octet_count = '0;
            fail_count = 0;
            packet_count = 0;
            fragment_count = 0;
            dropped_units = 0;
        end
        else
        begin
            if (pkt.valid && pkt.ready)
                compare_packet();
            if (nal.valid && nal.ready)
                packetize_unit(nal.nal_header, nal.nal_size);
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == ADDR_ENABLE)
                    send_on = pwdata[0];
                else if (paddr == ADDR_STEP)
                    ts_step = pwdata[16:0];
            end
        end
        packets_outstanding = packets_due.size();
    end

endmodule

[tb/tb_h264_rtp_fua_packetizer.sv]
`timescale 1ns / 1ps
module tb_h264_rtp_fua_packetizer;
    import h264fua_pkg::*;

    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_UNITS    = 70;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int packets_outstanding;
    int packet_count;
    int fragment_count;
    int dropped_units;
    int units_sent;
    int src_idle_pct;
    int snk_stall_pct;
    int idle_cycles;

    h264fua_nal_if nal_ch();
    h264fua_pkt_if pkt_ch();

    h264_rtp_fua_packetizer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .nal     (nal_ch),
        .pkt     (pkt_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    h264fua_stream_checker checker_i (
        .clk                 (clk),
        .rst_n               (rst_n),
        .nal                 (nal_ch),
        .pkt                 (pkt_ch),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .pready              (pready),
        .fail_count          (fail_count),
        .packets_outstanding (packets_outstanding),
        .packet_count        (packet_count),
        .fragment_count      (fragment_count),
        .dropped_units       (dropped_units)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver stalls
    always @(negedge clk)
        pkt_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (nal_ch.valid && nal_ch.ready) || (pkt_ch.valid && pkt_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d cycles with no word moving", idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_unit(input logic [7:0] hdr, input logic [16:0] size);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            nal_ch.valid <= 1'b0;
            @(negedge clk);
        end
        nal_ch.valid <= 1'b1;
        nal_ch.nal_header <= hdr;
        nal_ch.nal_size <= size;
        @(posedge clk);
        while (!nal_ch.ready)
            @(posedge clk);
        @(negedge clk);
        units_sent++;
    endtask

    task automatic drain();
        nal_ch.valid <= 1'b0;
        @(negedge clk);
        while (packets_outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [7:0] pick_header();
        logic [7:0] hdr;
        hdr = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 40)
            hdr[4:0] = 5'($urandom_range(0, 5));
        return hdr;
    endfunction

    function automatic logic [16:0] pick_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 17'($urandom_range(0, 1399));
        else if (r < 78)
            return 17'($urandom_range(1400, 8000));
        else if (r < 88)
            return 17'($urandom_range(1380, 2800));
        else if (r < 94)
            return 17'($urandom_range(8001, 65536));
        else
            return 17'($urandom_range(0, 131071));
    endfunction

    initial
    begin
        int phase;
        int i;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        nal_ch.valid = 1'b0;
        nal_ch.nal_header = '0;
        nal_ch.nal_size = '0;
        pkt_ch.ready = 1'b0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        units_sent = 0;
        idle_cycles = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // sending still disabled after reset
        send_unit(8'h65, 17'd100);
        send_unit(8'h05, 17'd5000);
        drain();
        write_reg(ADDR_ENABLE, 32'd1);

        // reset step, then boundaries of size and header
        send_unit(8'h00, 17'd0);
        send_unit(8'h65, 17'd1);
        send_unit(8'h41, 17'd1399);
        send_unit(8'h06, 17'd1400);
        send_unit(8'h7C, 17'd1401);
        send_unit(8'h85, 17'd2773);
        send_unit(8'hFF, 17'd2774);
        send_unit(8'h60, 17'd1387);
        send_unit(8'h05, 17'd1386);
        send_unit(8'h25, 17'd65535);
        send_unit(8'h45, 17'd65536);
        send_unit(8'h1F, 17'd65537);
        send_unit(8'hE7, 17'd131071);
        send_unit(8'h01, 17'd10000);
        drain();
        write_reg(ADDR_STEP, 32'd0);
        send_unit(8'h05, 17'd700);
        send_unit(8'h25, 17'd700);
        drain();
        write_reg(ADDR_STEP, 32'd131071);
        send_unit(8'h05, 17'd50);
        send_unit(8'h45, 17'd3000);
        send_unit(8'h1A, 17'd20);
        drain();

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 88; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 88; end
                default: begin src_idle_pct = 31; snk_stall_pct = 31; end
            endcase
            case (phase)
                0: write_reg(ADDR_STEP, 32'd90000);
                1: write_reg(ADDR_STEP, 32'($urandom_range(0, 90000)));
                2: write_reg(ADDR_STEP, 32'd1);
                default: write_reg(ADDR_STEP, 32'($urandom_range(0, 131071)));
            endcase
            write_reg(ADDR_ENABLE, 32'd0);
            send_unit(pick_header(), pick_size());
            send_unit(pick_header(), pick_size());
            drain();
            write_reg(ADDR_ENABLE, 32'd1);
            for (i = 0; i < PHASE_UNITS; i++)
                send_unit(pick_header(), pick_size());
            drain();
        end

        $display("covered %0d nal words (%0d dropped while disabled), %0d packet words, %0d fu-a",
                 units_sent, dropped_units, packet_count, fragment_count);
        $display("four idle/stall phases, steps 0 to 131071, sizes 0 to 131071");
        if (fail_count == 0 && packets_outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/h264fua_pkg.sv
hw/rtl/h264fua_if.sv
hw/rtl/h264fua_alu.sv
hw/rtl/h264_rtp_fua_packetizer.sv
hw/rtl/h264fua_checker.sv
tb/h264fua_stream_checker.sv
tb/tb_h264_rtp_fua_packetizer.sv
